@@ hdl/csn_pkg.sv @@
package csn_pkg;

    // field widths
    localparam int CNT_W = 16;
    localparam int LVL_W = 8;
    localparam int OFF_W = 8;

    // width of the full-scale clear code
    localparam int SAMPLE_BITS = 16;
    localparam logic [31:0] FULL_SCALE = (32'd1 << SAMPLE_BITS) - 32'd1;

    // quotient bits kept by the divider, larger quotients saturate the level anyway
    localparam int Q_W   = 10;
    localparam int REM_W = CNT_W + 8;
    localparam int DSH_W = CNT_W + Q_W;

    // pipeline stage numbering
    localparam int DIV_STAGES = Q_W;
    localparam int MAP_STG    = DIV_STAGES + 1;
    localparam int OUT_STG    = MAP_STG + 1;
    localparam int NUM_STG    = OUT_STG + 1;

    // level map limits
    localparam logic [LVL_W-1:0] LVL_MAX    = 8'd255;
    localparam logic [11:0]      DARK_SAT   = 12'd383;
    localparam logic [11:0]      BRIGHT_SAT = 12'd170;
    localparam logic [10:0]      PLAIN_SAT  = 11'd255;
    localparam logic [9:0]       RECIP3     = 10'd683;
    localparam int               RECIP3_SH  = 11;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DARK_CLEAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_CLEAR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_CLEAR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_CLEAR  = 3'd6;

    // per-lane stage loads and the map selection of the sample at the map stage
    typedef struct packed {
        logic [MAP_STG:0] load;
        logic             dark;
        logic             bright;
        logic             full;
    } lane_ctrl_t;

    // output stage load and clear-based forcing conditions
    typedef struct packed {
        logic load;
        logic zero;
        logic white;
        logic black_clear;
    } mrg_ctrl_t;

endpackage

@@ hdl/csn_div_step.sv @@
module csn_div_step
    import csn_pkg::*;
(
    input  logic [REM_W-1:0] rem_in,
    input  logic [DSH_W-1:0] divisor,
    output logic [REM_W-1:0] rem_out,
    output logic             q_bit
);

    logic [DSH_W-1:0] rem_ext;
    logic [DSH_W-1:0] diff;

    // one restoring step: subtract the shifted divisor when it fits
    always_comb begin
        rem_ext = {{(DSH_W-REM_W){1'b0}}, rem_in};
        diff    = rem_ext - divisor;
        q_bit   = (rem_ext >= divisor);
        rem_out = q_bit ? diff[REM_W-1:0] : rem_in;
    end

endmodule

@@ hdl/csn_lane.sv @@
module csn_lane
    import csn_pkg::*;
(
    input  logic                             aclk,
    input  lane_ctrl_t                       ctrl,
    input  logic [OFF_W-1:0]                 channel_offset,
    input  logic [CNT_W-1:0]                 clear_in,
    input  logic [CNT_W-1:0]                 count_in,
    input  logic [DIV_STAGES-1:0][CNT_W-1:0] clear_stg,
    output logic [LVL_W-1:0]                 level
);

    logic [REM_W-1:0] rem_reg [0:DIV_STAGES-1];
    logic [Q_W-1:0]   q_reg   [1:DIV_STAGES];
    logic             sat_reg [0:DIV_STAGES];
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;

    // quotient of 1024 or more: count at least four times clear
    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            rem_reg[0] <= {count_in, 8'd0};
            sat_reg[0] <= ({2'b00, count_in} >= {clear_in, 2'b00});
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        localparam int BIT = DIV_STAGES - k;
        logic [DSH_W-1:0] divisor;
        logic [REM_W-1:0] rem_out;
        logic             q_bit;
        logic [Q_W-1:0]   q_prev;

        assign divisor = {{Q_W{1'b0}}, clear_stg[k-1]} << BIT;

        csn_div_step u_step (
            .rem_in  (rem_reg[k-1]),
            .divisor (divisor),
            .rem_out (rem_out),
            .q_bit   (q_bit)
        );

        if (k == 1) begin : g_first
            assign q_prev = '0;
        end else begin : g_rest
            assign q_prev = q_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (ctrl.load[k]) begin
                q_reg[k]   <= q_prev | (Q_W'(q_bit) << BIT);
                sat_reg[k] <= sat_reg[k-1];
            end
        end

        if (k < DIV_STAGES) begin : g_rem
            always_ff @(posedge aclk) begin
                if (ctrl.load[k]) begin
                    rem_reg[k] <= rem_out;
                end
            end
        end else begin : g_norem
            // the last remainder is not needed
        end
    end

    // dark, bright or plain map, then clamp
    logic [Q_W-1:0] q;
    logic           sat;
    logic [11:0]    diff;
    logic [11:0]    t_dark;
    logic [9:0]     x_dark;
    logic [19:0]    prod_dark;
    logic [11:0]    s_bright;
    logic [9:0]     p_bright;
    logic [10:0]    p_plain;

    always_comb begin
        q         = q_reg[DIV_STAGES];
        sat       = sat_reg[DIV_STAGES];
        diff      = {2'b00, q} - {4'd0, channel_offset};
        t_dark    = ctrl.full ? {diff[10:0], 1'b0} : diff;
        x_dark    = {t_dark[8:0], 1'b0};
        prod_dark = 20'(x_dark) * 20'(RECIP3);
        s_bright  = ({2'b00, q} + {4'd0, channel_offset}) << ctrl.full;
        p_bright  = 10'(s_bright) * 10'd3;
        p_plain   = {1'b0, q} << ctrl.full;

        if (sat) begin
            level_next = LVL_MAX;
        end else if (ctrl.dark) begin
            if (q < {2'b00, channel_offset}) begin
                level_next = '0;
            end else if (t_dark >= DARK_SAT) begin
                level_next = LVL_MAX;
            end else begin
                level_next = prod_dark[RECIP3_SH +: LVL_W];
            end
        end else if (ctrl.bright) begin
            if (s_bright >= BRIGHT_SAT) begin
                level_next = LVL_MAX;
            end else begin
                level_next = p_bright[8:1];
            end
        end else begin
            if (p_plain >= PLAIN_SAT) begin
                level_next = LVL_MAX;
            end else begin
                level_next = p_plain[LVL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[MAP_STG]) begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

@@ hdl/csn_merge.sv @@
module csn_merge
    import csn_pkg::*;
(
    input  logic             aclk,
    input  mrg_ctrl_t        ctrl,
    input  logic [LVL_W-1:0] red_in,
    input  logic [LVL_W-1:0] green_in,
    input  logic [LVL_W-1:0] blue_in,
    input  logic [CNT_W-1:0] clear_in,
    input  logic [LVL_W-1:0] spread_limit,
    input  logic [LVL_W-1:0] black_level_limit,
    output logic [LVL_W-1:0] red_level,
    output logic [LVL_W-1:0] green_level,
    output logic [LVL_W-1:0] blue_level,
    output logic [CNT_W-1:0] clear_passed
);

    logic [LVL_W-1:0] largest;
    logic             close;
    logic [LVL_W-1:0] red_next;
    logic [LVL_W-1:0] green_next;
    logic [LVL_W-1:0] blue_next;
    logic [LVL_W-1:0] red_reg;
    logic [LVL_W-1:0] green_reg;
    logic [LVL_W-1:0] blue_reg;
    logic [CNT_W-1:0] clear_reg;

    always_comb begin
        largest = red_in;
        if (green_in > largest) begin
            largest = green_in;
        end
        if (blue_in > largest) begin
            largest = blue_in;
        end
        close = ((largest - red_in) <= spread_limit) &&
                ((largest - green_in) <= spread_limit) &&
                ((largest - blue_in) <= spread_limit);

        red_next   = red_in;
        green_next = green_in;
        blue_next  = blue_in;
        if (ctrl.zero) begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end else if (close && ctrl.white) begin
            red_next   = LVL_MAX;
            green_next = LVL_MAX;
            blue_next  = LVL_MAX;
        end else if (close && ctrl.black_clear && (largest < black_level_limit)) begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            clear_reg <= clear_in;
        end
    end

    assign red_level    = red_reg;
    assign green_level  = green_reg;
    assign blue_level   = blue_reg;
    assign clear_passed = clear_reg;

endmodule

@@ hdl/color_sample_normalizer_unit.sv @@
// color sample normalizer
// s_ channel: one raw sample per beat (clear, red, green, blue counts, 16 bit each)
// m_ channel: one result beat per sample (8-bit red, green, blue levels and the
//   clear count passed through)
// each color lane divides count*256 by clear in a ten-stage restoring divider,
//   one quotient bit per stage, then maps and clamps the level in one stage
// the merge stage finds the largest level, checks the spread and forces
//   white or black; it holds the output register
// an accepted sample passes the input, divider, map and output stages before m_tvalid shows it
// throughput: one beat per cycle unless m_tready stalls, set by the one-bit-per-stage divider pipeline
// every stage keeps its own valid bit and loads when it is empty or drains, so
//   bubbles close up and s_tready stays high until all 13 stages hold a beat
// a stall on m_tready holds the output beat; stages behind it keep filling
// reset (aresetn low, synchronous) empties the pipeline and loads the register
//   defaults; configuration writes are taken at any edge with cfg_wr_en high and
//   are meant to happen only while no beat is in flight
module color_sample_normalizer_unit
    import csn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // clear_count [15:0], red_count [31:16], green_count [47:32], blue_count [63:48]
    input  logic [63:0]          s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // red_level [7:0], green_level [15:8], blue_level [23:16], clear_passed [39:24]
    output logic [39:0]          m_tdata,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    // configuration registers
    logic [CNT_W-1:0] dark_clear_limit_reg;
    logic [CNT_W-1:0] bright_clear_limit_reg;
    logic [OFF_W-1:0] channel_offset_reg;
    logic [LVL_W-1:0] spread_limit_reg;
    logic [CNT_W-1:0] white_clear_limit_reg;
    logic [LVL_W-1:0] black_level_limit_reg;
    logic [CNT_W-1:0] black_clear_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_clear_limit_reg   <= 16'd250;
            bright_clear_limit_reg <= 16'd650;
            channel_offset_reg     <= 8'd40;
            spread_limit_reg       <= 8'd40;
            white_clear_limit_reg  <= 16'd800;
            black_level_limit_reg  <= 8'd60;
            black_clear_limit_reg  <= 16'd250;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DARK_CLEAR:   dark_clear_limit_reg   <= cfg_wr_data;
                REG_BRIGHT_CLEAR: bright_clear_limit_reg <= cfg_wr_data;
                REG_CHAN_OFFSET:  channel_offset_reg     <= cfg_wr_data[OFF_W-1:0];
                REG_SPREAD:       spread_limit_reg       <= cfg_wr_data[LVL_W-1:0];
                REG_WHITE_CLEAR:  white_clear_limit_reg  <= cfg_wr_data;
                REG_BLACK_LEVEL:  black_level_limit_reg  <= cfg_wr_data[LVL_W-1:0];
                REG_BLACK_CLEAR:  black_clear_limit_reg  <= cfg_wr_data;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // input fields
    logic [CNT_W-1:0] s_clear;
    logic [CNT_W-1:0] s_red;
    logic [CNT_W-1:0] s_green;
    logic [CNT_W-1:0] s_blue;

    assign s_clear = s_tdata[15:0];
    assign s_red   = s_tdata[31:16];
    assign s_green = s_tdata[47:32];
    assign s_blue  = s_tdata[63:48];

    // per-stage valid bits and the ready chain from the output back
    logic [NUM_STG-1:0] valid_reg;
    logic [NUM_STG-1:0] valid_next;
    logic [NUM_STG-1:0] stg_ready;

    always_comb begin
        stg_ready[OUT_STG] = !valid_reg[OUT_STG] || m_tready;
        for (int k = OUT_STG - 1; k >= 0; k--) begin
            stg_ready[k] = !valid_reg[k] || stg_ready[k+1];
        end
        for (int k = 0; k < NUM_STG; k++) begin
            if (stg_ready[k]) begin
                valid_next[k] = (k == 0) ? s_tvalid : valid_reg[(k == 0) ? 0 : k - 1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stg_ready[0];
    assign m_tvalid = valid_reg[OUT_STG];

    // clear count travels alongside the lanes up to the merge stage
    logic [OUT_STG-1:0][CNT_W-1:0] clear_reg;

    always_ff @(posedge aclk) begin
        if (stg_ready[0]) begin
            clear_reg[0] <= s_clear;
        end
        for (int k = 1; k < OUT_STG; k++) begin
            if (stg_ready[k]) begin
                clear_reg[k] <= clear_reg[k-1];
            end
        end
    end

    // map selection for the sample entering the map stage
    lane_ctrl_t lane_ctrl;
    logic [CNT_W-1:0] map_clear;

    always_comb begin
        map_clear        = clear_reg[DIV_STAGES];
        lane_ctrl.load   = stg_ready[MAP_STG:0];
        lane_ctrl.dark   = (map_clear < dark_clear_limit_reg);
        lane_ctrl.bright = (map_clear > bright_clear_limit_reg);
        lane_ctrl.full   = ({{(32-CNT_W){1'b0}}, map_clear} == FULL_SCALE);
    end

    logic [LVL_W-1:0] red_lv;
    logic [LVL_W-1:0] green_lv;
    logic [LVL_W-1:0] blue_lv;

    csn_lane u_lane_red (
        .aclk           (aclk),
        .ctrl           (lane_ctrl),
        .channel_offset (channel_offset_reg),
        .clear_in       (s_clear),
        .count_in       (s_red),
        .clear_stg      (clear_reg[DIV_STAGES-1:0]),
        .level          (red_lv)
    );

    csn_lane u_lane_green (
        .aclk           (aclk),
        .ctrl           (lane_ctrl),
        .channel_offset (channel_offset_reg),
        .clear_in       (s_clear),
        .count_in       (s_green),
        .clear_stg      (clear_reg[DIV_STAGES-1:0]),
        .level          (green_lv)
    );

    csn_lane u_lane_blue (
        .aclk           (aclk),
        .ctrl           (lane_ctrl),
        .channel_offset (channel_offset_reg),
        .clear_in       (s_clear),
        .count_in       (s_blue),
        .clear_stg      (clear_reg[DIV_STAGES-1:0]),
        .level          (blue_lv)
    );

    // forcing conditions for the sample entering the output stage
    mrg_ctrl_t mrg_ctrl;
    logic [CNT_W-1:0] mrg_clear;

    always_comb begin
        mrg_clear            = clear_reg[MAP_STG];
        mrg_ctrl.load        = stg_ready[OUT_STG];
        mrg_ctrl.zero        = (mrg_clear == '0);
        mrg_ctrl.white       = (mrg_clear > white_clear_limit_reg);
        mrg_ctrl.black_clear = (mrg_clear < black_clear_limit_reg);
    end

    logic [LVL_W-1:0] m_red;
    logic [LVL_W-1:0] m_green;
    logic [LVL_W-1:0] m_blue;
    logic [CNT_W-1:0] m_clear;

    csn_merge u_merge (
        .aclk              (aclk),
        .ctrl              (mrg_ctrl),
        .red_in            (red_lv),
        .green_in          (green_lv),
        .blue_in           (blue_lv),
        .clear_in          (mrg_clear),
        .spread_limit      (spread_limit_reg),
        .black_level_limit (black_level_limit_reg),
        .red_level         (m_red),
        .green_level       (m_green),
        .blue_level        (m_blue),
        .clear_passed      (m_clear)
    );

    assign m_tdata = {m_clear, m_blue, m_green, m_red};

    // a zero clear count always yields black
    a_zero_clear_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_clear == '0)) |-> ((m_red == '0) && (m_green == '0) && (m_blue == '0)))
        else $error("zero clear count gave nonzero levels");

    // input is refused only when the first stage holds a beat
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> valid_reg[0])
        else $error("input refused with first stage empty");

    // a mapped beat that cannot move on stays in the map stage
    a_map_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[MAP_STG] && !stg_ready[OUT_STG]) |=> valid_reg[MAP_STG])
        else $error("beat lost in map stage");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

@@ verif/color_sample_normalizer_unit_test.sv @@
`timescale 1ns / 1ps

module color_sample_normalizer_unit_test;
    import csn_pkg::*;

    // one raw sample beat, clear count in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0] blue;
        logic [CNT_W-1:0] green;
        logic [CNT_W-1:0] red;
        logic [CNT_W-1:0] clear;
    } rgbc_sample_t;

    // one level beat, red level in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0] clear_passed;
        logic [LVL_W-1:0] blue_level;
        logic [LVL_W-1:0] green_level;
        logic [LVL_W-1:0] red_level;
    } level_beat_t;

    // register defaults after reset
    localparam logic [15:0] RST_DARK_CLEAR   = 16'd250;
    localparam logic [15:0] RST_BRIGHT_CLEAR = 16'd650;
    localparam logic [15:0] RST_CHAN_OFFSET  = 16'd40;
    localparam logic [15:0] RST_SPREAD       = 16'd40;
    localparam logic [15:0] RST_WHITE_CLEAR  = 16'd800;
    localparam logic [15:0] RST_BLACK_LEVEL  = 16'd60;
    localparam logic [15:0] RST_BLACK_CLEAR  = 16'd250;

    // index past the register list, writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int IDLE_PCT       = 29;
    localparam int PIPE_TAIL      = 20;    // longer than the pipeline latency
    localparam int RX_HOLD_CYCLES = 300;   // long enough to fill all stages
    localparam int RUN_LIMIT_NS   = 2_000_000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;

    // shadow copy of the block's registers
    logic [CNT_W-1:0] dark_lim;
    logic [CNT_W-1:0] bright_lim;
    logic [OFF_W-1:0] chan_off;
    logic [LVL_W-1:0] spread_lim;
    logic [CNT_W-1:0] white_lim;
    logic [LVL_W-1:0] black_lvl;
    logic [CNT_W-1:0] black_clr;

    level_beat_t expected_levels[$];
    int          error_count     = 0;
    int          samples_sent    = 0;
    int          results_checked = 0;
    int          settings_used   = 0;

    // idling switches and the long receiver hold-off
    bit   tx_idle_on = 1'b1;
    bit   rx_idle_on = 1'b1;
    logic rx_hold    = 1'b0;
    event rx_hold_go;

    always #5 aclk = ~aclk;

    color_sample_normalizer_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // level predictor
    // ------------------------------------------------------------------

    // scale one count by the clear count, apply the dark / bright / plain map
    // and clamp; clear is nonzero here
    function automatic logic [LVL_W-1:0] scale_channel(input logic [CNT_W-1:0] cnt,
                                                       input logic [CNT_W-1:0] clr);
        longint q;
        longint off;
        longint mul;
        longint t;
        longint v;
        q   = (longint'({48'd0, cnt}) * 256) / longint'({48'd0, clr});
        off = longint'({56'd0, chan_off});
        // full-scale clear doubles the mapped value
        mul = ({16'd0, clr} == FULL_SCALE) ? 2 : 1;
        if (clr < dark_lim) begin
            // dark map wins when dark and bright both hold
            t = (q - off) * mul;
            v = (t <= 0) ? 0 : (t * 2) / 3;
        end else if (clr > bright_lim) begin
            v = ((q + off) * mul * 3) / 2;
        end else begin
            v = q * mul;
        end
        if (v > 255)
            v = 255;
        if (v < 0)
            v = 0;
        return v[LVL_W-1:0];
    endfunction

    function automatic level_beat_t predict_levels(input rgbc_sample_t smp);
        level_beat_t      res;
        logic [LVL_W-1:0] lv [3];
        int               largest;
        bit               close;
        res              = '0;
        res.clear_passed = smp.clear;
        // zero clear gives black with no forcing
        if (smp.clear == '0)
            return res;
        lv[0] = scale_channel(smp.red, smp.clear);
        lv[1] = scale_channel(smp.green, smp.clear);
        lv[2] = scale_channel(smp.blue, smp.clear);
        largest = 0;
        for (int i = 0; i < 3; i++)
            if (int'(lv[i]) > largest)
                largest = lv[i];
        close = 1'b1;
        for (int i = 0; i < 3; i++)
            if (largest - int'(lv[i]) > int'(spread_lim))
                close = 1'b0;
        if (close) begin
            // white is checked first and wins over black
            if (smp.clear > white_lim) begin
                for (int i = 0; i < 3; i++)
                    lv[i] = LVL_MAX;
            end else if (largest < int'(black_lvl) && smp.clear < black_clr) begin
                for (int i = 0; i < 3; i++)
                    lv[i] = '0;
            end
        end
        res.red_level   = lv[0];
        res.green_level = lv[1];
        res.blue_level  = lv[2];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one configuration beat; leaves cfg_wr_en high for a following beat
    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            REG_DARK_CLEAR:   dark_lim   = data;
            REG_BRIGHT_CLEAR: bright_lim = data;
            REG_CHAN_OFFSET:  chan_off   = data[OFF_W-1:0];
            REG_SPREAD:       spread_lim = data[LVL_W-1:0];
            REG_WHITE_CLEAR:  white_lim  = data;
            REG_BLACK_LEVEL:  black_lvl  = data[LVL_W-1:0];
            REG_BLACK_CLEAR:  black_clr  = data;
            default: ;
        endcase
    endtask

    // full register set, plus a write to the unused index; only while idle
    task automatic program_regs(input logic [15:0] dark, input logic [15:0] bright,
                                input logic [15:0] offs, input logic [15:0] spread,
                                input logic [15:0] white, input logic [15:0] blk_lvl,
                                input logic [15:0] blk_clr);
        cfg_beat(REG_DARK_CLEAR, dark);
        cfg_beat(REG_BRIGHT_CLEAR, bright);
        cfg_beat(REG_CHAN_OFFSET, offs);
        cfg_beat(REG_SPREAD, spread);
        cfg_beat(REG_UNUSED, 16'($urandom));
        cfg_beat(REG_WHITE_CLEAR, white);
        cfg_beat(REG_BLACK_LEVEL, blk_lvl);
        cfg_beat(REG_BLACK_CLEAR, blk_clr);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // offer one sample, with random gaps, until the block takes it
    task automatic send_sample(input rgbc_sample_t smp);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_levels.push_back(predict_levels(smp));
        samples_sent++;
    endtask

    function automatic rgbc_sample_t make_sample(input int unsigned clr, input int unsigned r,
                                                 input int unsigned g, input int unsigned b);
        rgbc_sample_t smp;
        smp.clear = clr[15:0];
        smp.red   = r[15:0];
        smp.green = g[15:0];
        smp.blue  = b[15:0];
        return smp;
    endfunction

    // mostly channels scaled off the clear count so the levels land in the
    // interesting range, sometimes close together to reach the forcing, and
    // some raw noise
    function automatic rgbc_sample_t random_sample();
        rgbc_sample_t smp;
        int unsigned  pick;
        int unsigned  base;
        int unsigned  jit;
        int unsigned  k;
        int unsigned  c;
        logic [15:0]  ch [3];
        pick = $urandom_range(99);
        if (pick < 5)
            smp.clear = '0;
        else if (pick < 10)
            smp.clear = 16'hFFFF;
        else if (pick < 25)
            smp.clear = 16'($urandom);
        else
            smp.clear = 16'($urandom_range(1, 1200));
        if ($urandom_range(99) < 15) begin
            for (int i = 0; i < 3; i++)
                ch[i] = 16'($urandom);
        end else begin
            base = $urandom_range(0, 420);
            jit  = $urandom_range(1) ? 12 : 200;
            for (int i = 0; i < 3; i++) begin
                k = base + $urandom_range(0, jit);
                c = (int'(smp.clear) * k) >> 8;
                ch[i] = (c > 65535) ? 16'hFFFF : c[15:0];
            end
        end
        smp.red   = ch[0];
        smp.green = ch[1];
        smp.blue  = ch[2];
        return smp;
    endfunction

    // stop offering and wait for every expected beat, then let the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge aclk);
        repeat (PIPE_TAIL) @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_sample(random_sample());
    endtask

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------

    // random m_tready, forced low during the hold-off
    always @(posedge aclk) begin
        if (rx_hold)
            m_tready <= 1'b0;
        else if (rx_idle_on)
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
        else
            m_tready <= 1'b1;
    end

    // hold-off counted here so the sender keeps pushing meanwhile
    always begin
        @(rx_hold_go);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin : check_levels
        level_beat_t got;
        level_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_levels.size() == 0) begin
                report_mismatch("unexpected result beat, clear", got.clear_passed, -1);
            end else begin
                want = expected_levels.pop_front();
                results_checked++;
                if (got.red_level !== want.red_level)
                    report_mismatch("red_level", got.red_level, want.red_level);
                if (got.green_level !== want.green_level)
                    report_mismatch("green_level", got.green_level, want.green_level);
                if (got.blue_level !== want.blue_level)
                    report_mismatch("blue_level", got.blue_level, want.blue_level);
                if (got.clear_passed !== want.clear_passed)
                    report_mismatch("clear_passed", got.clear_passed, want.clear_passed);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset defaults, every special case and the map boundaries
    task automatic test_directed();
        send_sample(make_sample(0, 65535, 65535, 65535));       // zero clear
        send_sample(make_sample(0, 0, 0, 0));
        send_sample(make_sample(65535, 65535, 65535, 65535));   // full scale, white
        send_sample(make_sample(65535, 0, 20000, 40000));       // full scale, spread
        send_sample(make_sample(65534, 65535, 65535, 65535));
        send_sample(make_sample(100, 10, 50, 100));             // dark, below offset
        send_sample(make_sample(200, 60, 60, 60));              // forced black
        send_sample(make_sample(900, 900, 900, 900));           // forced white
        send_sample(make_sample(700, 100, 300, 650));           // bright, no forcing
        send_sample(make_sample(400, 100, 200, 300));           // plain map
        send_sample(make_sample(10, 65535, 0, 5));              // channel far above clear
        send_sample(make_sample(1, 0, 1, 65535));
        send_sample(make_sample(500, 400, 400, 300));           // tie on the largest
        send_sample(make_sample(500, 300, 300, 300));           // close, no forcing
        send_sample(make_sample(249, 100, 100, 100));           // map boundaries
        send_sample(make_sample(250, 100, 100, 100));
        send_sample(make_sample(650, 500, 500, 500));
        send_sample(make_sample(651, 500, 500, 500));
        send_sample(make_sample(800, 800, 800, 800));
        send_sample(make_sample(801, 800, 800, 800));
        wait_idle();
    endtask

    // all-zero and all-ones registers, then dark overlapping bright with
    // white and black both reachable
    task automatic test_register_extremes();
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_random(40);
        wait_idle();
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_random(40);
        wait_idle();
        program_regs(16'd1000, 16'd100, 16'd40, 16'd255, 16'd300, 16'd255, 16'd2000);
        send_random(40);
        wait_idle();
        program_regs(RST_DARK_CLEAR, RST_BRIGHT_CLEAR, RST_CHAN_OFFSET, RST_SPREAD,
                     RST_WHITE_CLEAR, RST_BLACK_LEVEL, RST_BLACK_CLEAR);
    endtask

    // receiver stalls while samples keep coming, so s_tready has to drop
    task automatic test_backpressure();
        -> rx_hold_go;
        send_random(80);
        wait_idle();
    endtask

    // sender stops until the pipe is empty, then resumes
    task automatic test_sender_pause();
        send_random(20);
        wait_idle();
        send_random(20);
        wait_idle();
    endtask

    // full rate on both sides
    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random(200);
        wait_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // random register sets; 8-bit registers get junk in the upper byte
    task automatic test_random_settings();
        for (int ph = 0; ph < 8; ph++) begin
            program_regs(16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)),
                         16'($urandom), 16'($urandom),
                         ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500)),
                         16'($urandom), 16'($urandom_range(0, 1500)));
            send_random(110);
            wait_idle();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        dark_lim    = RST_DARK_CLEAR;
        bright_lim  = RST_BRIGHT_CLEAR;
        chan_off    = RST_CHAN_OFFSET[OFF_W-1:0];
        spread_lim  = RST_SPREAD[LVL_W-1:0];
        white_lim   = RST_WHITE_CLEAR;
        black_lvl   = RST_BLACK_LEVEL[LVL_W-1:0];
        black_clr   = RST_BLACK_CLEAR;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_register_extremes();
        test_backpressure();
        test_sender_pause();
        test_full_rate();
        test_random_settings();

        $display("covered %0d samples, %0d level beats checked, %0d register sets",
                 samples_sent, results_checked, settings_used);
        $display("included output hold-off with input stall, sender pauses, full rate");
        if (error_count == 0) begin
            $display("[color_sample_normalizer_unit] OK");
        end else begin
            $display("[color_sample_normalizer_unit] ERROR");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("[color_sample_normalizer_unit] ERROR");
        $finish;
    end

endmodule
